// ===== rtl/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared types and constants for the pixel color converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int CH_W       = 8;
  localparam int HUE_W      = 9;
  localparam int HUE_NUM_W  = 14;   // 60 * 255 fits in 14 bits
  localparam int SAT_NUM_W  = 16;   // 255 * 255 fits in 16 bits
  localparam int QUO_W      = 8;    // both quotients stay below 256

  localparam logic [HUE_W-1:0] HUE_BASE_RED   = 9'd0;
  localparam logic [HUE_W-1:0] HUE_BASE_WRAP  = 9'd360;
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 9'd240;

  // Classified pixel, handed from the front to the back through the queue
  typedef struct packed {
    logic [HUE_NUM_W-1:0] hue_num;
    logic [CH_W-1:0]      hue_den;
    logic                 hue_neg;
    logic [HUE_W-1:0]     hue_base;
    logic [SAT_NUM_W-1:0] sat_num;
    logic [CH_W-1:0]      sat_den;
    logic [CH_W-1:0]      value;
  } rgbhsv_work_t;

  // One stage of the shared division pipeline
  typedef struct packed {
    logic [HUE_NUM_W-1:0] hue_rem;
    logic [CH_W-1:0]      hue_den;
    logic [QUO_W-1:0]     hue_q;
    logic                 hue_neg;
    logic [HUE_W-1:0]     hue_base;
    logic [SAT_NUM_W-1:0] sat_rem;
    logic [CH_W-1:0]      sat_den;
    logic [QUO_W-1:0]     sat_q;
    logic [CH_W-1:0]      value;
  } rgbhsv_div_t;

endpackage

// ===== rtl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one 8-bit RGB pixel per unstalled clock to hue, saturation, value.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with in_red, in_green, in_blue. A word
// is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_hue (0..359 degrees),
// out_saturation (255 = 1.0) and out_brightness (largest channel).
// Throughput: one pixel per clock, sustained, while out_stall stays low.
// Path of a word: the accepting edge writes it into the queue, the divider
// stages then carry it on (one quotient bit per stage), and the output
// register takes it last.
// A front end classifies each pixel and pushes it into a QUEUE_DEPTH-entry
// queue; the back end pops it into the divider pipeline.
// With out_valid and out_stall high, output word and whole divider pipe hold;
// the queue keeps taking words until it fills, then in_stall rises.
// Reset (rst_n low, synchronous) empties the queue and the pipe.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter import rgbhsv_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CH_W-1:0]     in_red,
  input  logic [CH_W-1:0]     in_green,
  input  logic [CH_W-1:0]     in_blue,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HUE_W-1:0]    out_hue,
  output logic [CH_W-1:0]     out_saturation,
  output logic [CH_W-1:0]     out_brightness
);

  rgbhsv_work_t push_data, pop_data;
  logic         push, pop, q_full, q_valid;

  rgbhsv_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .q_full   (q_full),
    .push     (push),
    .work     (push_data)
  );

  rgbhsv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (pop_data)
  );

  rgbhsv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

endmodule

// ===== rtl/rgbhsv_front.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Accepts pixels, finds max/min and the hue sector, and forms the dividends
// and divisors for the back end.
// ----------------------------------------------------------------------------
module rgbhsv_front import rgbhsv_pkg::*; (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CH_W-1:0]     in_red,
  input  logic [CH_W-1:0]     in_green,
  input  logic [CH_W-1:0]     in_blue,
  input  logic                q_full,
  output logic                push,
  output rgbhsv_work_t        work
);

  logic [CH_W-1:0] mx, mn, delta, mag;
  logic [CH_W:0]   diff;
  logic            is_red, is_green;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue  > mx) mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue  < mn) mn = in_blue;
    delta = mx - mn;

    is_red   = (mx == in_red);
    is_green = !is_red && (mx == in_green);

    if (is_red) begin
      diff = {1'b0, in_green} - {1'b0, in_blue};
    end else if (is_green) begin
      diff = {1'b0, in_blue} - {1'b0, in_red};
    end else begin
      diff = {1'b0, in_red} - {1'b0, in_green};
    end
    mag = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];

    work.value   = mx;
    work.sat_num = {delta, 8'd0} - SAT_NUM_W'(delta);
    work.sat_den = (mx == '0) ? CH_W'(1) : mx;

    if (delta == '0) begin
      // grey: force hue to zero through a zero dividend
      work.hue_num  = '0;
      work.hue_den  = CH_W'(1);
      work.hue_neg  = 1'b0;
      work.hue_base = HUE_BASE_RED;
    end else begin
      work.hue_num  = {mag, 6'd0} - {4'd0, mag, 2'd0};
      work.hue_den  = delta;
      work.hue_neg  = diff[CH_W];
      if (is_red)
        work.hue_base = diff[CH_W] ? HUE_BASE_WRAP : HUE_BASE_RED;
      else if (is_green)
        work.hue_base = HUE_BASE_GREEN;
      else
        work.hue_base = HUE_BASE_BLUE;
    end
  end

endmodule

// ===== rtl/rgbhsv_queue.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV queue
// Small register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module rgbhsv_queue import rgbhsv_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rgbhsv_work_t  push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output rgbhsv_work_t  pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rgbhsv_work_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)
        count_r <= count_r + CNT_W'(1);
      else if (pop && !push)
        count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/rgbhsv_back.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV back end
// Eight-stage restoring divider for hue and saturation, one quotient bit per
// stage, then hue assembly into the output register.
// ----------------------------------------------------------------------------
module rgbhsv_back import rgbhsv_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rgbhsv_work_t        q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HUE_W-1:0]    out_hue,
  output logic [CH_W-1:0]     out_saturation,
  output logic [CH_W-1:0]     out_brightness
);

  localparam int NSTG = QUO_W;

  rgbhsv_div_t     stg_in  [NSTG];
  rgbhsv_div_t     stg_nxt [NSTG];
  rgbhsv_div_t     pipe_r  [NSTG];
  logic [NSTG-1:0] vld_r;
  logic            out_valid_r;
  logic [HUE_W-1:0] hue_r, hue_nxt;
  logic [CH_W-1:0]  sat_r, val_r;
  logic             en;
  rgbhsv_div_t      last;
  logic [QUO_W-1:0] q_ceil;

  // whole pipe moves together unless the output word is held
  assign en  = !out_valid_r || !out_stall;
  assign pop = en && q_valid;

  always_comb begin
    stg_in[0].hue_rem  = q_data.hue_num;
    stg_in[0].hue_den  = q_data.hue_den;
    stg_in[0].hue_q    = '0;
    stg_in[0].hue_neg  = q_data.hue_neg;
    stg_in[0].hue_base = q_data.hue_base;
    stg_in[0].sat_rem  = q_data.sat_num;
    stg_in[0].sat_den  = q_data.sat_den;
    stg_in[0].sat_q    = '0;
    stg_in[0].value    = q_data.value;
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    localparam int K = NSTG - 1 - s;
    logic [HUE_NUM_W:0]   hue_sh;
    logic [SAT_NUM_W-1:0] sat_sh;

    if (s > 0) begin : g_link
      assign stg_in[s] = pipe_r[s-1];
    end

    assign hue_sh = (HUE_NUM_W+1)'(stg_in[s].hue_den) << K;
    assign sat_sh = SAT_NUM_W'(stg_in[s].sat_den) << K;

    always_comb begin
      stg_nxt[s] = stg_in[s];
      if ({1'b0, stg_in[s].hue_rem} >= hue_sh) begin
        stg_nxt[s].hue_rem  = stg_in[s].hue_rem - hue_sh[HUE_NUM_W-1:0];
        stg_nxt[s].hue_q[K] = 1'b1;
      end
      if (stg_in[s].sat_rem >= sat_sh) begin
        stg_nxt[s].sat_rem  = stg_in[s].sat_rem - sat_sh;
        stg_nxt[s].sat_q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) pipe_r[s] <= stg_nxt[s];
    end
  end

  // floor of a negative quotient rounds the magnitude up
  always_comb begin
    last    = pipe_r[NSTG-1];
    q_ceil  = last.hue_q + QUO_W'(last.hue_rem != '0);
    if (last.hue_neg)
      hue_nxt = last.hue_base - HUE_W'(q_ceil);
    else
      hue_nxt = last.hue_base + HUE_W'(last.hue_q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r <= hue_nxt;
      sat_r <= last.sat_q;
      val_r <= last.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NSTG-2:0], q_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = val_r;

endmodule

// ===== rtl/rgbhsv_checker.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV checker
// Port-level assertions on the output channel of the converter.
// ----------------------------------------------------------------------------
module rgbhsv_checker import rgbhsv_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [HUE_W-1:0] out_hue,
  input logic [CH_W-1:0]  out_saturation,
  input logic [CH_W-1:0]  out_brightness
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_hue) && $stable(out_saturation)
      && $stable(out_brightness))
    else $error("output word changed while stalled");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < 9'd360)
    else $error("hue out of range");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == '0 |-> out_saturation == '0 && out_hue == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturation == '0 |-> out_hue == '0)
    else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hue        (out_hue),
  .out_saturation (out_saturation),
  .out_brightness (out_brightness)
);
